FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/core/wfr_pkg.sv
// ----------------------------------------------------------------------------
// wfr_pkg
// Types, codes and helpers of the WebSocket frame receiver.
// ----------------------------------------------------------------------------
package wfr_pkg;

    localparam int ResultMax = 6;

    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_LENHI   = 3'd2,
        PH_LENLO   = 3'd3,
        PH_SKIP    = 3'd4,
        PH_PAYLOAD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ACT_DROP  = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_ECHO  = 2'd2,
        ACT_CLOSE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_START  = 3'd0,
        KIND_BYTE   = 3'd1,
        KIND_END    = 3'd2,
        KIND_TX     = 3'd3,
        KIND_CLOSED = 3'd4,
        KIND_ERROR  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RESERVED  = 3'd1,
        ERR_MASKED    = 3'd2,
        ERR_LEN64     = 3'd3,
        ERR_CTRL_LONG = 3'd4,
        ERR_OPCODE    = 3'd5
    } err_t;

    localparam logic [3:0]  OP_CONT  = 4'h0;
    localparam logic [3:0]  OP_TEXT  = 4'h1;
    localparam logic [3:0]  OP_CLOSE = 4'h8;
    localparam logic [3:0]  OP_PING  = 4'h9;
    localparam logic [3:0]  OP_PONG  = 4'hA;

    localparam logic [7:0]  PONG_HDR     = 8'h8A;
    localparam logic [7:0]  MASK_FLAG    = 8'h80;
    localparam logic [15:0] CTRL_MAX_LEN = 16'd125;
    localparam logic [6:0]  LEN_EXT16    = 7'd126;
    localparam logic [6:0]  LEN_EXT64    = 7'd127;
    localparam logic [3:0]  SKIP_MASKED  = 4'd4;
    localparam logic [3:0]  SKIP_LEN64   = 4'd8;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
    } result_t;

    typedef struct packed {
        logic [2:0]                   count;
        result_t [ResultMax-1:0]      res;
    } bundle_t;

    typedef struct packed {
        logic       can_load;
        logic [2:0] count;
    } buf_status_t;

    function automatic result_t mk_result(kind_t kind, logic [7:0] data, err_t err);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        return r;
    endfunction

    // mask byte 0 is bits 31:24
    function automatic logic [7:0] mask_byte(logic [31:0] key, logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = key[31:24];
            2'd1: b = key[23:16];
            2'd2: b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/wfr_parser.sv
// ----------------------------------------------------------------------------
// wfr_parser
// Frame state and the per-byte decode that yields this item's results.
// ----------------------------------------------------------------------------
module wfr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [31:0]      mask_key,
    output wfr_pkg::bundle_t bundle
);

    wfr_pkg::phase_t  phase_reg, phase_next;
    wfr_pkg::action_t act_reg, act_next;
    logic [4:0]       hdr_reg, hdr_next;       // {FIN, opcode}
    logic [15:0]      left_reg, left_next;
    logic [3:0]       skip_reg, skip_next;
    logic             inmsg_reg, inmsg_next;
    logic [31:0]      mask_reg, mask_next;
    logic [1:0]       midx_reg, midx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wfr_pkg::PH_HDR1;
            act_reg   <= wfr_pkg::ACT_DROP;
            hdr_reg   <= '0;
            left_reg  <= '0;
            skip_reg  <= '0;
            inmsg_reg <= 1'b0;
            mask_reg  <= '0;
            midx_reg  <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            hdr_reg   <= hdr_next;
            left_reg  <= left_next;
            skip_reg  <= skip_next;
            inmsg_reg <= inmsg_next;
            mask_reg  <= mask_next;
            midx_reg  <= midx_next;
        end
    end

    always_comb begin
        logic [2:0]  n;
        logic        do_start;
        logic [15:0] frame_len;
        logic [15:0] left_dec;
        logic [3:0]  skip_dec;
        logic [3:0]  op;

        phase_next = phase_reg;
        act_next   = act_reg;
        hdr_next   = hdr_reg;
        left_next  = left_reg;
        skip_next  = skip_reg;
        inmsg_next = inmsg_reg;
        mask_next  = mask_reg;
        midx_next  = midx_reg;
        bundle     = '0;
        n          = '0;
        do_start   = 1'b0;
        frame_len  = '0;
        left_dec   = left_reg;
        skip_dec   = skip_reg;
        op         = hdr_reg[3:0];

        unique case (phase_reg)
            wfr_pkg::PH_HDR1: begin
                hdr_next   = {rx_byte[7], rx_byte[3:0]};
                skip_next  = {1'b0, rx_byte[6:4]};   // reserved bits, judged next byte
                phase_next = wfr_pkg::PH_HDR2;
            end
            wfr_pkg::PH_HDR2: begin
                phase_next = wfr_pkg::PH_HDR1;
                priority if (skip_reg != 4'd0) begin
                    skip_next = '0;
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_ERROR, 8'h00,
                                                       wfr_pkg::ERR_RESERVED);
                    n = n + 3'd1;
                end else if (rx_byte[7]) begin
                    skip_next  = wfr_pkg::SKIP_MASKED;
                    phase_next = wfr_pkg::PH_SKIP;
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_ERROR, 8'h00,
                                                       wfr_pkg::ERR_MASKED);
                    n = n + 3'd1;
                end else if (rx_byte[6:0] == wfr_pkg::LEN_EXT64) begin
                    skip_next  = wfr_pkg::SKIP_LEN64;
                    phase_next = wfr_pkg::PH_SKIP;
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_ERROR, 8'h00,
                                                       wfr_pkg::ERR_LEN64);
                    n = n + 3'd1;
                end else if (rx_byte[6:0] == wfr_pkg::LEN_EXT16) begin
                    phase_next = wfr_pkg::PH_LENHI;
                end else begin
                    do_start  = 1'b1;
                    frame_len = {9'd0, rx_byte[6:0]};
                end
            end
            wfr_pkg::PH_LENHI: begin
                left_next  = {rx_byte, 8'h00};
                phase_next = wfr_pkg::PH_LENLO;
            end
            wfr_pkg::PH_LENLO: begin
                do_start  = 1'b1;
                frame_len = left_reg | {8'h00, rx_byte};
            end
            wfr_pkg::PH_SKIP: begin
                if (skip_reg != 4'd0) begin
                    skip_dec = skip_reg - 4'd1;
                end
                skip_next = skip_dec;
                if (skip_dec == 4'd0) begin
                    phase_next = wfr_pkg::PH_HDR1;
                end
            end
            wfr_pkg::PH_PAYLOAD: begin
                if (act_reg == wfr_pkg::ACT_DATA) begin
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_BYTE, rx_byte,
                                                       wfr_pkg::ERR_NONE);
                    n = n + 3'd1;
                end else if (act_reg == wfr_pkg::ACT_ECHO) begin
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_TX,
                        rx_byte ^ wfr_pkg::mask_byte(mask_reg, midx_reg), wfr_pkg::ERR_NONE);
                    n = n + 3'd1;
                    midx_next = midx_reg + 2'd1;
                end
                if (left_reg != 16'd0) begin
                    left_dec = left_reg - 16'd1;
                end
                left_next = left_dec;
                if (left_dec == 16'd0) begin
                    phase_next = wfr_pkg::PH_HDR1;
                    if (act_reg == wfr_pkg::ACT_DATA) begin
                        if (hdr_reg[4]) begin
                            bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_END, 8'h00,
                                                               wfr_pkg::ERR_NONE);
                            n = n + 3'd1;
                            inmsg_next = 1'b0;
                        end else begin
                            inmsg_next = 1'b1;
                        end
                    end else if (act_reg == wfr_pkg::ACT_CLOSE) begin
                        bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_CLOSED, 8'h00,
                                                           wfr_pkg::ERR_NONE);
                        n = n + 3'd1;
                    end
                end
            end
            default: begin
                phase_next = wfr_pkg::PH_HDR1;
            end
        endcase

        // header complete: classify the frame
        if (do_start) begin
            phase_next = wfr_pkg::PH_HDR1;
            left_next  = frame_len;
            midx_next  = '0;
            if (op[3] && (frame_len > wfr_pkg::CTRL_MAX_LEN)) begin
                bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_ERROR, 8'h00,
                                                   wfr_pkg::ERR_CTRL_LONG);
                n = n + 3'd1;
                left_next = '0;
            end else begin
                priority if (op == wfr_pkg::OP_PING) begin
                    act_next  = wfr_pkg::ACT_ECHO;
                    mask_next = mask_key;
                    bundle.res[0] = wfr_pkg::mk_result(wfr_pkg::KIND_TX, wfr_pkg::PONG_HDR,
                                                       wfr_pkg::ERR_NONE);
                    bundle.res[1] = wfr_pkg::mk_result(wfr_pkg::KIND_TX,
                        wfr_pkg::MASK_FLAG | {1'b0, frame_len[6:0]}, wfr_pkg::ERR_NONE);
                    bundle.res[2] = wfr_pkg::mk_result(wfr_pkg::KIND_TX, mask_key[31:24],
                                                       wfr_pkg::ERR_NONE);
                    bundle.res[3] = wfr_pkg::mk_result(wfr_pkg::KIND_TX, mask_key[23:16],
                                                       wfr_pkg::ERR_NONE);
                    bundle.res[4] = wfr_pkg::mk_result(wfr_pkg::KIND_TX, mask_key[15:8],
                                                       wfr_pkg::ERR_NONE);
                    bundle.res[5] = wfr_pkg::mk_result(wfr_pkg::KIND_TX, mask_key[7:0],
                                                       wfr_pkg::ERR_NONE);
                    n = 3'd6;
                end else if (op == wfr_pkg::OP_PONG) begin
                    act_next = wfr_pkg::ACT_DROP;
                end else if (op == wfr_pkg::OP_CLOSE) begin
                    act_next = wfr_pkg::ACT_CLOSE;
                    if (frame_len == 16'd0) begin
                        bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_CLOSED, 8'h00,
                                                           wfr_pkg::ERR_NONE);
                        n = n + 3'd1;
                    end
                end else if ((op == wfr_pkg::OP_TEXT) ||
                             ((op == wfr_pkg::OP_CONT) && inmsg_reg)) begin
                    act_next = wfr_pkg::ACT_DATA;
                    if (op == wfr_pkg::OP_TEXT) begin
                        bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_START, 8'h00,
                                                           wfr_pkg::ERR_NONE);
                        n = n + 3'd1;
                    end
                    if (frame_len == 16'd0) begin
                        if (hdr_reg[4]) begin
                            bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_END, 8'h00,
                                                               wfr_pkg::ERR_NONE);
                            n = n + 3'd1;
                            inmsg_next = 1'b0;
                        end else begin
                            inmsg_next = 1'b1;
                        end
                    end
                end else begin
                    act_next = wfr_pkg::ACT_DROP;
                    bundle.res[n] = wfr_pkg::mk_result(wfr_pkg::KIND_ERROR, 8'h00,
                                                       wfr_pkg::ERR_OPCODE);
                    n = n + 3'd1;
                end
                if (frame_len != 16'd0) begin
                    phase_next = wfr_pkg::PH_PAYLOAD;
                end
            end
        end

        bundle.count = n;
    end

endmodule

FILE: rtl/core/wfr_result_buffer.sv
// ----------------------------------------------------------------------------
// wfr_result_buffer
// Holds one item's results, handing out one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module wfr_result_buffer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  wfr_pkg::bundle_t     bundle,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output wfr_pkg::result_t     result,
    output logic                 result_last,
    output wfr_pkg::buf_status_t status
);

    wfr_pkg::result_t [wfr_pkg::ResultMax-1:0] res_reg, res_next;
    logic [2:0]                                cnt_reg, cnt_next;
    logic                                      take;

    assign take            = (cnt_reg != 3'd0) && m_tready;
    assign status.can_load = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign status.count    = cnt_reg;
    assign m_tvalid        = (cnt_reg != 3'd0);
    assign result          = res_reg[0];
    assign result_last     = (cnt_reg == 3'd1);

    always_comb begin
        res_next = res_reg;
        cnt_next = cnt_reg;
        if (load) begin
            res_next = bundle.res;
            cnt_next = bundle.count;
        end else if (take) begin
            // advance: next result moves to the head
            for (int i = 0; i < wfr_pkg::ResultMax - 1; i++) begin
                res_next[i] = res_reg[i+1];
            end
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

FILE: rtl/core/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// websocket_frame_receiver
// Byte-serial parser for server-to-client WebSocket frames with PONG echo.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                          | tuser | tlast
//  --------+-----------+--------------------------------+-------+----------------
//  s_      | in        | [7:0] rx_byte, [39:8] mask_key | -     | -
//  m_      | out       | [7:0] data_byte, [10:8] error  | kind  | last of an item
//
//  An item is decoded in the cycle it is accepted; its results (zero to six)
//  land together in the result buffer and leave it one per cycle while
//  m_tready is high. A new item is taken every cycle while each item yields
//  at most one result and m_tready is high; an item with more results (up to
//  six for a PING header) holds s_tready low until its last result is being
//  taken, as all results leave through the single result port. Reset (aresetn
//  low, synchronous) empties the buffer and returns the parser to the first
//  header byte. s_tready follows m_tready when exactly one result is waiting.
//
module websocket_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [7:0] rx_byte, [39:8] mask_key

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [10:8] error_code, [15:11] zero
    output logic [2:0]  m_tuser,    // [2:0] kind
    output logic        m_tlast
);

`include "assert_macros.svh"

    logic                 accept;
    wfr_pkg::bundle_t     bundle;
    wfr_pkg::result_t     result;
    logic                 result_last;
    wfr_pkg::buf_status_t buf_status;

    // take an item only when the buffer is free or frees this cycle
    assign s_tready = buf_status.can_load;
    assign accept   = s_tvalid && s_tready;

    wfr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (accept),
        .rx_byte  (s_tdata[7:0]),
        .mask_key (s_tdata[39:8]),
        .bundle   (bundle)
    );

    wfr_result_buffer u_result_buffer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (accept),
        .bundle      (bundle),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .result      (result),
        .result_last (result_last),
        .status      (buf_status)
    );

    assign m_tdata = {5'd0, result.err, result.data};
    assign m_tuser = result.kind;
    assign m_tlast = result_last;

    // ready only with room for a whole new item
    `ASSERT_PROP(a_ready_room, aclk, aresetn, s_tready |-> (buf_status.count <= 3'd1))
    // last mark only on the final buffered result
    `ASSERT_PROP(a_last_final, aclk, aresetn, (m_tvalid && m_tlast) |-> (buf_status.count == 3'd1))
    // error results carry a code, other kinds never do
    `ASSERT_PROP(a_err_code, aclk, aresetn, m_tvalid |-> ((result.kind == wfr_pkg::KIND_ERROR) == (result.err != wfr_pkg::ERR_NONE)))
    // no item yields more results than the buffer holds
    `ASSERT_NEVER(a_bundle_fit, aclk, aresetn, accept && (bundle.count > 3'd6))

endmodule

FILE: bench/websocket_frame_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver_test
// Feeds received link bytes through the frame parser and checks every result
// item against a cycle-free model of the parser kept inside this bench.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_test;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 80;

    typedef struct {
        logic [7:0]  value;
        logic [31:0] key;
        logic        hold;
    } rx_item_t;

    typedef struct {
        wfr_pkg::kind_t kind;
        logic [7:0]     data;
        wfr_pkg::err_t  err;
        logic           last;
    } parsed_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = 40'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    rx_item_t       wire_bytes_q[$];
    parsed_result_t parsed_results_q[$];

    int mismatch_count = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;
    int queued_bytes   = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    logic        hold_next = 1'b0;
    logic        gen_open  = 1'b0;
    logic [15:0] stall_bits = 16'hFFFF;
    logic [3:0]  stall_step = 4'd0;

    // parser model state
    wfr_pkg::phase_t  rx_phase       = wfr_pkg::PH_HDR1;
    logic             hdr_fin        = 1'b0;
    logic [3:0]       hdr_op         = 4'h0;
    logic [2:0]       rsv_held       = 3'd0;
    logic [15:0]      remaining      = 16'd0;
    logic [3:0]       skip_count     = 4'd0;
    logic             msg_open       = 1'b0;
    logic [31:0]      echo_key       = 32'd0;
    logic [1:0]       echo_idx       = 2'd0;
    wfr_pkg::action_t payload_action = wfr_pkg::ACT_DROP;

    websocket_frame_receiver dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] rx_byte, [39:8] mask_key
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] data_byte, [10:8] error_code, [15:11] zero
        .m_tuser  (m_tuser),    // [2:0] kind
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // mask byte 0 is the top byte of the key
    function automatic logic [7:0] key_byte(logic [31:0] key, logic [1:0] idx);
        logic [31:0] shifted;
        shifted = key >> (24 - 8 * int'(idx));
        return shifted[7:0];
    endfunction

    function automatic void add_result(wfr_pkg::kind_t kind, logic [7:0] data,
                                       wfr_pkg::err_t err);
        parsed_result_t r;
        r.kind = kind;
        r.data = data;
        r.err  = err;
        r.last = 1'b0;
        parsed_results_q.push_back(r);
    endfunction

    // final data frame ends the message, otherwise the message stays open
    function automatic void close_data();
        if (hdr_fin) begin
            add_result(wfr_pkg::KIND_END, 8'h00, wfr_pkg::ERR_NONE);
            msg_open = 1'b0;
        end else begin
            msg_open = 1'b1;
        end
    endfunction

    // header complete: pick what to do with the payload
    function automatic void open_frame(logic [15:0] len, logic [31:0] key);
        rx_phase  = wfr_pkg::PH_HDR1;
        remaining = len;
        echo_idx  = 2'd0;
        if (hdr_op[3] && len > wfr_pkg::CTRL_MAX_LEN) begin
            // oversized control frame: no payload is consumed
            add_result(wfr_pkg::KIND_ERROR, 8'h00, wfr_pkg::ERR_CTRL_LONG);
            remaining = 16'd0;
            return;
        end
        if (hdr_op == wfr_pkg::OP_PING) begin
            payload_action = wfr_pkg::ACT_ECHO;
            echo_key       = key;
            add_result(wfr_pkg::KIND_TX, wfr_pkg::PONG_HDR, wfr_pkg::ERR_NONE);
            add_result(wfr_pkg::KIND_TX, wfr_pkg::MASK_FLAG | {1'b0, len[6:0]},
                       wfr_pkg::ERR_NONE);
            for (int i = 0; i < 4; i++) begin
                add_result(wfr_pkg::KIND_TX, key_byte(key, i[1:0]), wfr_pkg::ERR_NONE);
            end
        end else if (hdr_op == wfr_pkg::OP_PONG) begin
            payload_action = wfr_pkg::ACT_DROP;
        end else if (hdr_op == wfr_pkg::OP_CLOSE) begin
            payload_action = wfr_pkg::ACT_CLOSE;
            if (len == 16'd0)
                add_result(wfr_pkg::KIND_CLOSED, 8'h00, wfr_pkg::ERR_NONE);
        end else if (hdr_op == wfr_pkg::OP_TEXT ||
                     (hdr_op == wfr_pkg::OP_CONT && msg_open)) begin
            payload_action = wfr_pkg::ACT_DATA;
            if (hdr_op == wfr_pkg::OP_TEXT)
                add_result(wfr_pkg::KIND_START, 8'h00, wfr_pkg::ERR_NONE);
            if (len == 16'd0)
                close_data();
        end else begin
            // unsupported opcode, or a continuation with nothing open
            payload_action = wfr_pkg::ACT_DROP;
            add_result(wfr_pkg::KIND_ERROR, 8'h00, wfr_pkg::ERR_OPCODE);
        end
        if (len != 16'd0)
            rx_phase = wfr_pkg::PH_PAYLOAD;
    endfunction

    // advance the model by one accepted byte; queue what it must produce
    function automatic void parse_rx_byte(logic [7:0] b, logic [31:0] key);
        int             prior_count;
        parsed_result_t r;
        prior_count = parsed_results_q.size();
        case (rx_phase)
            wfr_pkg::PH_HDR1: begin
                hdr_fin  = b[7];
                hdr_op   = b[3:0];
                rsv_held = b[6:4];
                rx_phase = wfr_pkg::PH_HDR2;
            end
            wfr_pkg::PH_HDR2: begin
                rx_phase = wfr_pkg::PH_HDR1;
                if (rsv_held != 3'd0) begin
                    rsv_held = 3'd0;
                    add_result(wfr_pkg::KIND_ERROR, 8'h00, wfr_pkg::ERR_RESERVED);
                end else if (b[7]) begin
                    skip_count = wfr_pkg::SKIP_MASKED;
                    rx_phase   = wfr_pkg::PH_SKIP;
                    add_result(wfr_pkg::KIND_ERROR, 8'h00, wfr_pkg::ERR_MASKED);
                end else if (b[6:0] == wfr_pkg::LEN_EXT64) begin
                    skip_count = wfr_pkg::SKIP_LEN64;
                    rx_phase   = wfr_pkg::PH_SKIP;
                    add_result(wfr_pkg::KIND_ERROR, 8'h00, wfr_pkg::ERR_LEN64);
                end else if (b[6:0] == wfr_pkg::LEN_EXT16) begin
                    rx_phase = wfr_pkg::PH_LENHI;
                end else begin
                    open_frame({9'd0, b[6:0]}, key);
                end
            end
            wfr_pkg::PH_LENHI: begin
                remaining = {b, 8'h00};
                rx_phase  = wfr_pkg::PH_LENLO;
            end
            wfr_pkg::PH_LENLO: begin
                open_frame({remaining[15:8], b}, key);
            end
            wfr_pkg::PH_SKIP: begin
                if (skip_count != 4'd0)
                    skip_count = skip_count - 4'd1;
                if (skip_count == 4'd0)
                    rx_phase = wfr_pkg::PH_HDR1;
            end
            wfr_pkg::PH_PAYLOAD: begin
                if (payload_action == wfr_pkg::ACT_DATA) begin
                    add_result(wfr_pkg::KIND_BYTE, b, wfr_pkg::ERR_NONE);
                end else if (payload_action == wfr_pkg::ACT_ECHO) begin
                    add_result(wfr_pkg::KIND_TX, b ^ key_byte(echo_key, echo_idx),
                               wfr_pkg::ERR_NONE);
                    echo_idx = echo_idx + 2'd1;
                end
                if (remaining != 16'd0)
                    remaining = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    rx_phase = wfr_pkg::PH_HDR1;
                    if (payload_action == wfr_pkg::ACT_DATA)
                        close_data();
                    else if (payload_action == wfr_pkg::ACT_CLOSE)
                        add_result(wfr_pkg::KIND_CLOSED, 8'h00, wfr_pkg::ERR_NONE);
                end
            end
            default: begin
                rx_phase = wfr_pkg::PH_HDR1;
            end
        endcase
        // mark the final result of this byte
        if (parsed_results_q.size() > prior_count) begin
            r = parsed_results_q.pop_back();
            r.last = 1'b1;
            parsed_results_q.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------

    task automatic add_byte(input logic [7:0] value, input logic [31:0] key);
        rx_item_t it;
        it.value  = value;
        it.key    = key;
        it.hold   = hold_next;
        hold_next = 1'b0;
        wire_bytes_q.push_back(it);
        queued_bytes++;
    endtask

    // len_mode: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
    task automatic add_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                             input logic masked, input int len_mode, input logic [15:0] len);
        logic [6:0] len7;
        len7 = (len_mode == 0) ? len[6:0] :
               (len_mode == 1) ? wfr_pkg::LEN_EXT16 : wfr_pkg::LEN_EXT64;
        add_byte({fin, rsv, op}, $urandom);
        add_byte({masked, len7}, $urandom);
        if (rsv != 3'd0)
            return;
        if (masked) begin
            repeat (4) add_byte(8'($urandom_range(0, 255)), $urandom);
            return;
        end
        if (len_mode == 2) begin
            repeat (8) add_byte(8'($urandom_range(0, 255)), $urandom);
            return;
        end
        if (len_mode == 1) begin
            add_byte(len[15:8], $urandom);
            add_byte(len[7:0], $urandom);
            if (op[3] && len > wfr_pkg::CTRL_MAX_LEN)
                return;
        end
        repeat (int'(len)) add_byte(8'($urandom_range(0, 255)), $urandom);
        // track the message so continuations mostly land inside one
        if (op == wfr_pkg::OP_TEXT || (op == wfr_pkg::OP_CONT && gen_open))
            gen_open = !fin;
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_item_t nxt;
        logic     present;
        present = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_rx_byte(s_tdata[7:0], s_tdata[39:8]);
            // load only when the presented item is gone or nothing is presented
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (wire_bytes_q.size() > 0 &&
                             (!wire_bytes_q[0].hold || parsed_results_q.size() == 0)) begin
                    nxt     = wire_bytes_q.pop_front();
                    present = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                s_tvalid <= present;
                if (present)
                    s_tdata <= {nxt.key, nxt.value};
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows a random 16-bit pattern, redrawn each period
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [15:0] bits;
        bits = stall_bits;
        if (stall_step == 4'd0) begin
            bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
            stall_bits = bits;
        end
        m_tready   <= bits[stall_step];
        stall_step = stall_step + 4'd1;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        parsed_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (parsed_results_q.size() == 0) begin
                report_mismatch("unpredicted result, kind", int'(m_tuser), 0);
            end else begin
                want = parsed_results_q.pop_front();
                if (m_tuser != want.kind)
                    report_mismatch("kind", int'(m_tuser), int'(want.kind));
                if (m_tdata[7:0] != want.data)
                    report_mismatch("data_byte", int'(m_tdata[7:0]), int'(want.data));
                if (m_tdata[10:8] != want.err)
                    report_mismatch("error_code", int'(m_tdata[10:8]), int'(want.err));
                if (m_tlast != want.last)
                    report_mismatch("last", int'(m_tlast), int'(want.last));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("websocket_frame_receiver_test: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int          directed_bytes;
        int          sel;
        int          len_mode;
        logic [3:0]  op;
        logic [15:0] len;

        // empty final text frame: start and end on the length byte
        add_byte(8'h81, 32'h0000_0000);
        add_byte(8'h00, 32'h0000_0000);
        // reserved bits set, all-ones byte and key on the second header byte
        add_byte(8'hF1, 32'hFFFF_FFFF);
        add_byte(8'hFF, 32'hFFFF_FFFF);
        // open a text message with one byte, not final
        add_byte(8'h01, $urandom);
        add_byte(8'h01, $urandom);
        add_byte(8'hFF, $urandom);
        // ping inside the open message, mask from an all-ones key
        add_byte(8'h89, $urandom);
        add_byte(8'h01, 32'hFFFF_FFFF);
        add_byte(8'h00, $urandom);
        // new text start abandons the open message, stays open (empty, not final)
        add_byte(8'h01, $urandom);
        add_byte(8'h00, $urandom);
        // empty final continuation ends it
        add_byte(8'h80, $urandom);
        add_byte(8'h00, $urandom);
        // continuation with no message open
        add_byte(8'h80, $urandom);
        add_byte(8'h00, $urandom);
        // masked frame: four bytes skipped
        add_byte(8'h82, $urandom);
        add_byte(8'h85, $urandom);
        repeat (4) add_byte(8'($urandom_range(0, 255)), $urandom);
        // pong with a 16-bit length over the control limit
        add_byte(8'h8A, $urandom);
        add_byte(8'h7E, $urandom);
        add_byte(8'hFF, $urandom);
        add_byte(8'hFF, $urandom);
        // close with one payload byte
        add_byte(8'h88, $urandom);
        add_byte(8'h01, $urandom);
        add_byte(8'h00, $urandom);
        directed_bytes = queued_bytes;

        // random frames; let everything drain before the first one
        hold_next = 1'b1;
        while (queued_bytes - directed_bytes < RANDOM_BYTES) begin
            sel      = $urandom_range(0, 99);
            len_mode = ($urandom_range(0, 6) == 0) ? 1 : 0;
            if ($urandom_range(0, 19) == 0)
                hold_next = 1'b1;
            if (sel < 40) begin
                op  = (gen_open && $urandom_range(0, 2) != 0) ? wfr_pkg::OP_CONT
                                                              : wfr_pkg::OP_TEXT;
                len = 16'($urandom_range(0, 6));
                if (sel < 2) begin
                    len_mode = 1;
                    len      = 16'($urandom_range(126, 140));
                end
                add_frame(1'($urandom_range(0, 1)), 3'd0, op, 1'b0, len_mode, len);
            end else if (sel < 55) begin
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(120, 125))
                                                  : 16'($urandom_range(0, 9));
                add_frame(1'($urandom_range(0, 1)), 3'd0, wfr_pkg::OP_PING, 1'b0,
                          len_mode, len);
            end else if (sel < 62) begin
                add_frame(1'b1, 3'd0, wfr_pkg::OP_PONG, 1'b0, len_mode,
                          16'($urandom_range(0, 4)));
            end else if (sel < 70) begin
                add_frame(1'b1, 3'd0, wfr_pkg::OP_CLOSE, 1'b0, len_mode,
                          16'($urandom_range(0, 3)));
            end else if (sel < 76) begin
                // opcodes 2..7 and 11..15
                op = 4'($urandom_range(0, 10));
                op = (op < 4'd6) ? op + 4'd2 : op + 4'd5;
                add_frame(1'($urandom_range(0, 1)), 3'd0, op, 1'b0, len_mode,
                          16'($urandom_range(0, 4)));
            end else if (sel < 82) begin
                op = 4'h8 | 4'($urandom_range(0, 7));
                add_frame(1'b1, 3'd0, op, 1'b0, 1, 16'($urandom_range(126, 65535)));
            end else if (sel < 86) begin
                add_frame(1'($urandom_range(0, 1)), 3'd0, 4'($urandom_range(0, 15)), 1'b0,
                          2, 16'd0);
            end else if (sel < 90) begin
                add_frame(1'($urandom_range(0, 1)), 3'd0, 4'($urandom_range(0, 15)), 1'b1,
                          0, 16'($urandom_range(0, 125)));
            end else if (sel < 94) begin
                add_frame(1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 2), 16'($urandom_range(0, 5)));
            end else begin
                // loose header: any bits, short payload
                add_frame(1'($urandom_range(0, 1)),
                          ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0,
                          4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 2), 16'($urandom_range(0, 5)));
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // hold until every byte is in and every predicted result is out
        while (wire_bytes_q.size() != 0 || s_tvalid || parsed_results_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0)
            $display("websocket_frame_receiver_test: PASS");
        else
            $display("websocket_frame_receiver_test: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/wfr_pkg.sv
rtl/core/wfr_parser.sv
rtl/core/wfr_result_buffer.sv
rtl/core/websocket_frame_receiver.sv
bench/websocket_frame_receiver_test.sv
